// ===== rtl/gec_pkg.sv =====
// ----------------------------------------------------------------------------
// gec_pkg
// Shared widths, reset value and the remainder-code type of the Golomb encoder.
// ----------------------------------------------------------------------------
package gec_pkg;

	localparam int DIV_W  = 11;
	localparam int VAL_W  = 11;
	localparam int CODE_W = 64;
	localparam int BC_W   = 7;
	localparam int TAIL_W = DIV_W + 1;
	localparam int TLEN_W = 4;
	localparam int IDX_W  = 6;

	localparam logic [DIV_W-1:0] DIVISOR_RST = 11'd4;

	typedef struct packed {
		logic [TAIL_W-1:0] bits;
		logic [TLEN_W-1:0] len;
	} tail_t;

endpackage

// ===== rtl/gec_div.sv =====
// ----------------------------------------------------------------------------
// gec_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module gec_div import gec_pkg::*; #(
	parameter int VALUE_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] x,
	input  logic [DIV_W-1:0]      m,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quo,
	output logic [DIV_W-1:0]      rem
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      m_q;
	logic [DIV_W:0]        trial;
	logic                  qbit;

	assign trial = {rem_q, dvd_q[VALUE_BITS-1]};
	assign qbit  = (trial >= {1'b0, m_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= x;
			rem_q <= '0;
			m_q   <= m;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			quo_q <= {quo_q[VALUE_BITS-2:0], qbit};
			if (qbit) begin
				rem_q <= DIV_W'(trial - {1'b0, m_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding busy cycle");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with an exhausted step count");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < m_q)
		else $error("divider remainder not below divisor");

endmodule

// ===== rtl/gec_trunc.sv =====
// ----------------------------------------------------------------------------
// gec_trunc
// Truncated binary code of the remainder, left aligned behind the stop bit.
// ----------------------------------------------------------------------------
module gec_trunc import gec_pkg::*; (
	input  logic [DIV_W-1:0] m,
	input  logic [DIV_W-1:0] r,
	output tail_t            tail
);

	logic [DIV_W-1:0]  below;
	logic [TLEN_W-1:0] b;
	logic [DIV_W:0]    pow;
	logic [DIV_W:0]    u;
	logic [DIV_W-1:0]  code;
	logic [TLEN_W-1:0] nbits;
	logic [TLEN_W-1:0] sh;

	always_comb begin
		for (int k = 0; k < DIV_W; k++) begin
			below[k] = ({1'b0, m} > ((DIV_W + 1)'(1) << k));
		end
	end

	always_comb begin
		b   = TLEN_W'($countones(below));
		pow = (DIV_W + 1)'(1) << b;
		u   = pow - {1'b0, m};
		if ({1'b0, r} < u) begin
			code  = r;
			nbits = b - 1'b1;
		end else begin
			code  = DIV_W'({1'b0, r} + u);
			nbits = b;
		end
		sh        = TLEN_W'(DIV_W) - nbits;
		tail.bits = {1'b0, DIV_W'(code << sh)};
		tail.len  = nbits + 1'b1;
	end

endmodule

// ===== rtl/gec_pack.sv =====
// ----------------------------------------------------------------------------
// gec_pack
// Chunk builder: fills bit by bit or in bulk ones, holds one output chunk.
// ----------------------------------------------------------------------------
module gec_pack import gec_pkg::*; #(
	parameter int VALUE_BITS = 11,
	parameter int CHUNK_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] q,
	input  tail_t                 tail,
	output logic                  done,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CODE_W-1:0]     code_bits,
	output logic [BC_W-1:0]       bit_count,
	output logic                  last_chunk
);

	localparam int FILL_W = $clog2(CHUNK_BITS + 1);
	localparam int CMP_W  = ((VALUE_BITS > FILL_W) ? VALUE_BITS : FILL_W) + 1;
	localparam logic [CODE_W-1:0] BULK = ~({CODE_W{1'b1}} >> CHUNK_BITS);

	typedef enum logic [1:0] {
		P_IDLE,
		P_FILL,
		P_PUSH
	} pstate_t;

	pstate_t               state_q;
	logic [VALUE_BITS-1:0] ones_q;
	logic [TAIL_W-1:0]     tail_q;
	logic [TLEN_W-1:0]     tlen_q;
	logic [CODE_W-1:0]     chunk_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  last_q;
	logic                  done_q;
	logic                  out_valid_q;
	logic [CODE_W-1:0]     code_bits_q;
	logic [BC_W-1:0]       bit_count_q;
	logic                  last_chunk_q;

	logic                  slot_free;
	logic                  load;
	logic                  bulk;
	logic                  fin;
	logic                  nbit;
	logic [IDX_W-1:0]      idx;

	assign slot_free = !out_valid_q || !out_stall;
	assign load      = (state_q == P_PUSH) && slot_free;
	assign bulk      = (fill_q == '0) && (CMP_W'(ones_q) >= CMP_W'(CHUNK_BITS));
	assign fin       = (ones_q == '0) && (tlen_q == TLEN_W'(1));
	assign nbit      = (ones_q != '0) ? 1'b1 : tail_q[TAIL_W-1];
	assign idx       = IDX_W'(CODE_W - 1) - IDX_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= P_IDLE;
			ones_q       <= '0;
			tail_q       <= '0;
			tlen_q       <= '0;
			chunk_q      <= '0;
			fill_q       <= '0;
			last_q       <= 1'b0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			code_bits_q  <= '0;
			bit_count_q  <= '0;
			last_chunk_q <= 1'b0;
		end else begin
			done_q      <= load && last_q;
			out_valid_q <= load || (out_valid_q && out_stall);
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						ones_q  <= q;
						tail_q  <= tail.bits;
						tlen_q  <= tail.len;
						chunk_q <= '0;
						fill_q  <= '0;
						state_q <= P_FILL;
					end
				end
				P_FILL: begin
					if (bulk) begin
						chunk_q <= BULK;
						fill_q  <= FILL_W'(CHUNK_BITS);
						ones_q  <= ones_q - VALUE_BITS'(CHUNK_BITS);
						last_q  <= 1'b0;
						state_q <= P_PUSH;
					end else begin
						chunk_q[idx] <= nbit;
						fill_q       <= fill_q + 1'b1;
						if (ones_q != '0) begin
							ones_q <= ones_q - 1'b1;
						end else begin
							tail_q <= {tail_q[TAIL_W-2:0], 1'b0};
							tlen_q <= tlen_q - 1'b1;
						end
						if (fin || fill_q == FILL_W'(CHUNK_BITS - 1)) begin
							last_q  <= fin;
							state_q <= P_PUSH;
						end
					end
				end
				P_PUSH: begin
					if (slot_free) begin
						code_bits_q  <= chunk_q;
						bit_count_q  <= BC_W'(fill_q);
						last_chunk_q <= last_q;
						chunk_q      <= '0;
						fill_q       <= '0;
						if (last_q) begin
							state_q <= P_IDLE;
						end else begin
							state_q <= P_FILL;
						end
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign out_valid  = out_valid_q;
	assign code_bits  = code_bits_q;
	assign bit_count  = bit_count_q;
	assign last_chunk = last_chunk_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CHUNK_BITS))
		else $error("chunk fill beyond chunk size");

	a_tail_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == P_FILL) |-> tlen_q != '0)
		else $error("building a chunk with no stop bit left");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bit_count_q != '0 && bit_count_q <= BC_W'(CHUNK_BITS)))
		else $error("output chunk bit count out of range");

endmodule

// ===== rtl/golomb_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// golomb_encoder_unit
// Golomb encoder with truncated binary remainder, chunked output.
// Each value is Golomb coded with the divisor register (zero acts as one):
// the quotient as a run of ones, a zero stop bit, then the remainder in
// truncated binary. The codeword leaves first bit first in chunks of up to
// CHUNK_BITS bits, left aligned at bit 63, with the final chunk flagged.
// One value is in flight at a time. Per value: the value is taken, the
// bit-serial divider forms VALUE_BITS quotient bits, quotient and
// remainder are handed to the chunk builder, which fills each chunk one
// codeword bit per cycle (a chunk made only of quotient ones is set at once)
// and then loads it into the output register once that is free; after the
// final chunk the unit returns to idle. The output register holds a chunk
// while the builder works on the next one. A pending divisor write is taken
// before a waiting value.
// ----------------------------------------------------------------------------
module golomb_encoder_unit import gec_pkg::*; #(
	parameter int VALUE_BITS = 11,
	parameter int CHUNK_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DIV_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [VAL_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] code_bits,
	output logic [BC_W-1:0]   bit_count,
	output logic              last_chunk
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_DIV,
		T_PACK
	} tstate_t;

	tstate_t               state_q;
	logic [DIV_W-1:0]      divisor_q;
	logic [DIV_W-1:0]      m_eff;
	logic                  in_xfer;
	logic                  div_done;
	logic [VALUE_BITS-1:0] quo;
	logic [DIV_W-1:0]      rem;
	tail_t                 tail;
	logic                  pack_done;

	assign m_eff     = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
	assign in_stall  = (state_q != T_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == T_IDLE);
	assign in_xfer   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIVISOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			divisor_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			unique case (state_q)
				T_IDLE: if (in_xfer) state_q <= T_DIV;
				T_DIV:  if (div_done) state_q <= T_PACK;
				T_PACK: if (pack_done) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	gec_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_xfer),
		.x     (value[VALUE_BITS-1:0]),
		.m     (m_eff),
		.done  (div_done),
		.quo   (quo),
		.rem   (rem)
	);

	gec_trunc u_trunc (
		.m   (m_eff),
		.r   (rem),
		.tail(tail)
	);

	gec_pack #(
		.VALUE_BITS(VALUE_BITS),
		.CHUNK_BITS(CHUNK_BITS)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_done),
		.q         (quo),
		.tail      (tail),
		.done      (pack_done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_bits (code_bits),
		.bit_count (bit_count),
		.last_chunk(last_chunk)
	);

endmodule
